FILE: design/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types, widths and the control program of the square-free splitter.
// ----------------------------------------------------------------------------
package sfs_pkg;

    localparam int VALUE_BITS = 31;                  // working width of n
    localparam int IN_BITS    = 31;                  // width of the value port
    localparam int ROOT_BITS  = 16;                  // width of square_root_part
    localparam int FREE_BITS  = 31;                  // width of square_free_part
    localparam int D_BITS     = VALUE_BITS / 2 + 1;  // trial divisor width
    localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);
    localparam int PC_BITS    = 5;

    localparam logic [D_BITS-1:0] FIRST_DIVISOR = D_BITS'(2);

    typedef logic [PC_BITS-1:0] sfs_pc_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV_START,
        OP_HIT,
        OP_MUL_AD,
        OP_MUL_BD,
        OP_MUL_BR,
        OP_WR_A,
        OP_WR_A_REM1,
        OP_WR_B,
        OP_INC_D,
        OP_EMIT
    } sfs_op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_IN_VALID,
        C_DIV_DONE,
        C_LOOP_EXIT,
        C_REM_NZ,
        C_NOT_ODD,
        C_REM_NE_D,
        C_REM_LE1,
        C_OUT_FREE
    } sfs_cond_t;

    // hold: stay on this step when the condition is false
    typedef struct packed {
        sfs_op_t   op;
        sfs_cond_t cond;
        logic      hold;
        sfs_pc_t   target;
    } sfs_uword_t;

    typedef struct packed {
        logic start;
    } sfs_div_ctrl_t;

    typedef struct packed {
        logic busy;
    } sfs_div_stat_t;

    localparam sfs_pc_t S_IDLE  = sfs_pc_t'(0);
    localparam sfs_pc_t S_DIV   = sfs_pc_t'(1);
    localparam sfs_pc_t S_DIVW  = sfs_pc_t'(2);
    localparam sfs_pc_t S_TEST  = sfs_pc_t'(3);
    localparam sfs_pc_t S_CHK   = sfs_pc_t'(4);
    localparam sfs_pc_t S_HIT   = sfs_pc_t'(5);
    localparam sfs_pc_t S_HMUL  = sfs_pc_t'(6);
    localparam sfs_pc_t S_HWR   = sfs_pc_t'(7);
    localparam sfs_pc_t S_MISS  = sfs_pc_t'(8);
    localparam sfs_pc_t S_MMUL  = sfs_pc_t'(9);
    localparam sfs_pc_t S_MWR   = sfs_pc_t'(10);
    localparam sfs_pc_t S_INC   = sfs_pc_t'(11);
    localparam sfs_pc_t S_TAIL  = sfs_pc_t'(12);
    localparam sfs_pc_t S_TPAIR = sfs_pc_t'(13);
    localparam sfs_pc_t S_TAMUL = sfs_pc_t'(14);
    localparam sfs_pc_t S_TAWR  = sfs_pc_t'(15);
    localparam sfs_pc_t S_TB    = sfs_pc_t'(16);
    localparam sfs_pc_t S_TBWR  = sfs_pc_t'(17);
    localparam sfs_pc_t S_LEFT  = sfs_pc_t'(18);
    localparam sfs_pc_t S_LMUL  = sfs_pc_t'(19);
    localparam sfs_pc_t S_LWR   = sfs_pc_t'(20);
    localparam sfs_pc_t S_OUT   = sfs_pc_t'(21);

    function automatic sfs_uword_t mk(sfs_op_t op, sfs_cond_t cond, logic hold,
                                      sfs_pc_t target);
        sfs_uword_t w;
        w.op     = op;
        w.cond   = cond;
        w.hold   = hold;
        w.target = target;
        return w;
    endfunction

    // Control store: one word per step
    function automatic sfs_uword_t ucode(sfs_pc_t pc);
        sfs_uword_t w;
        case (pc)
            S_IDLE:  w = mk(OP_LOAD,      C_IN_VALID,  1'b1, S_DIV);
            S_DIV:   w = mk(OP_DIV_START, C_NEVER,     1'b0, S_IDLE);
            S_DIVW:  w = mk(OP_NOP,       C_DIV_DONE,  1'b1, S_TEST);
            S_TEST:  w = mk(OP_NOP,       C_LOOP_EXIT, 1'b0, S_TAIL);
            S_CHK:   w = mk(OP_NOP,       C_REM_NZ,    1'b0, S_MISS);
            S_HIT:   w = mk(OP_HIT,       C_NOT_ODD,   1'b0, S_DIV);
            S_HMUL:  w = mk(OP_MUL_AD,    C_NEVER,     1'b0, S_IDLE);
            S_HWR:   w = mk(OP_WR_A,      C_ALWAYS,    1'b0, S_DIV);
            S_MISS:  w = mk(OP_NOP,       C_NOT_ODD,   1'b0, S_INC);
            S_MMUL:  w = mk(OP_MUL_BD,    C_NEVER,     1'b0, S_IDLE);
            S_MWR:   w = mk(OP_WR_B,      C_NEVER,     1'b0, S_IDLE);
            S_INC:   w = mk(OP_INC_D,     C_ALWAYS,    1'b0, S_DIV);
            S_TAIL:  w = mk(OP_NOP,       C_NOT_ODD,   1'b0, S_LEFT);
            S_TPAIR: w = mk(OP_NOP,       C_REM_NE_D,  1'b0, S_TB);
            S_TAMUL: w = mk(OP_MUL_AD,    C_NEVER,     1'b0, S_IDLE);
            S_TAWR:  w = mk(OP_WR_A_REM1, C_ALWAYS,    1'b0, S_LEFT);
            S_TB:    w = mk(OP_MUL_BD,    C_NEVER,     1'b0, S_IDLE);
            S_TBWR:  w = mk(OP_WR_B,      C_NEVER,     1'b0, S_IDLE);
            S_LEFT:  w = mk(OP_NOP,       C_REM_LE1,   1'b0, S_OUT);
            S_LMUL:  w = mk(OP_MUL_BR,    C_NEVER,     1'b0, S_IDLE);
            S_LWR:   w = mk(OP_WR_B,      C_NEVER,     1'b0, S_IDLE);
            S_OUT:   w = mk(OP_EMIT,      C_OUT_FREE,  1'b1, S_IDLE);
            default: w = mk(OP_NOP,       C_ALWAYS,    1'b0, S_IDLE);
        endcase
        return w;
    endfunction

endpackage

FILE: design/sfs_divider.sv
// ----------------------------------------------------------------------------
// sfs_divider
// Restoring divider, one quotient bit per cycle; gives quotient and remainder.
// ----------------------------------------------------------------------------
module sfs_divider (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sfs_pkg::sfs_div_ctrl_t               ctrl,
    input  logic [sfs_pkg::VALUE_BITS-1:0]       dividend,
    input  logic [sfs_pkg::D_BITS-1:0]           divisor,
    output sfs_pkg::sfs_div_stat_t               stat,
    output logic [sfs_pkg::VALUE_BITS-1:0]       quotient,
    output logic [sfs_pkg::D_BITS-1:0]           remainder
);

    logic [sfs_pkg::CNT_BITS-1:0]   cnt_reg,  cnt_next;
    logic [sfs_pkg::VALUE_BITS-1:0] q_reg,    q_next;
    logic [sfs_pkg::D_BITS-1:0]     r_reg,    r_next;
    logic [sfs_pkg::D_BITS-1:0]     dvs_reg,  dvs_next;
    logic [sfs_pkg::D_BITS:0]       trial;
    logic [sfs_pkg::D_BITS:0]       diff;
    logic                           fits;

    assign trial = {r_reg, q_reg[sfs_pkg::VALUE_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = ~diff[sfs_pkg::D_BITS];

    always_comb
    begin
        cnt_next = cnt_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        dvs_next = dvs_reg;
        if (ctrl.start)
        begin
            cnt_next = sfs_pkg::CNT_BITS'(sfs_pkg::VALUE_BITS);
            q_next   = dividend;
            r_next   = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            // shift in one dividend bit, subtract when it fits
            cnt_next = cnt_reg - 1'b1;
            q_next   = {q_reg[sfs_pkg::VALUE_BITS-2:0], fits};
            r_next   = fits ? diff[sfs_pkg::D_BITS-1:0] : trial[sfs_pkg::D_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

FILE: design/square_free_split_core.sv
// ----------------------------------------------------------------------------
// square_free_split_core
// Splits n into a and b with n = a*a*b and b square-free, by trial division.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries value (n). Output channel
//   out_valid/out_ready carries square_root_part (a) and square_free_part (b).
//   One result transaction follows every input transaction, in order.
//   A microcoded sequencer walks divisors 2, 3, 5, 7, 9, ... while d*d <= n'.
//   Each trial divisor runs one pass of the bit-serial divider plus its
//   control steps; a found factor costs one more divider pass, and a large
//   prime n takes up to about 23200 trials. One item is worked at a time;
//   in_ready is high only while the sequencer sits at its idle step.
//   The result sits in an output register, so a new input is taken while the
//   previous result still waits; if out_ready stays low the sequencer holds
//   at its emit step until the register frees up.
//   Reset clears the step counter, the divider count and out_valid.
// ----------------------------------------------------------------------------
module square_free_split_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [sfs_pkg::IN_BITS-1:0]       value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [sfs_pkg::ROOT_BITS-1:0]     square_root_part,
    output logic [sfs_pkg::FREE_BITS-1:0]     square_free_part
);

    localparam int VB = sfs_pkg::VALUE_BITS;
    localparam int DB = sfs_pkg::D_BITS;

    sfs_pkg::sfs_pc_t        pc_reg, pc_next;
    sfs_pkg::sfs_uword_t     uw;
    logic                    cond_true;
    logic                    out_free;

    logic [VB-1:0]           rem_reg,  rem_next;
    logic [DB-1:0]           d_reg,    d_next;
    logic [DB-1:0]           a_reg,    a_next;
    logic [VB-1:0]           b_reg,    b_next;
    logic                    odd_reg,  odd_next;
    logic [2*VB-1:0]         prod_reg, prod_next;
    logic [VB-1:0]           mul_x;
    logic [VB-1:0]           mul_y;
    logic                    out_valid_reg, out_valid_next;
    logic [sfs_pkg::ROOT_BITS-1:0] root_reg, root_next;
    logic [sfs_pkg::FREE_BITS-1:0] free_reg, free_next;

    sfs_pkg::sfs_div_ctrl_t  div_ctrl;
    sfs_pkg::sfs_div_stat_t  div_stat;
    logic [VB-1:0]           div_q;
    logic [DB-1:0]           div_r;

    sfs_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (rem_reg),
        .divisor   (d_reg),
        .stat      (div_stat),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign uw             = sfs_pkg::ucode(pc_reg);
    assign out_free       = ~out_valid_reg | out_ready;
    assign in_ready       = (pc_reg == sfs_pkg::S_IDLE);
    assign div_ctrl.start = (uw.op == sfs_pkg::OP_DIV_START);

    // condition select and step sequencing
    always_comb
    begin
        case (uw.cond)
            sfs_pkg::C_NEVER:     cond_true = 1'b0;
            sfs_pkg::C_ALWAYS:    cond_true = 1'b1;
            sfs_pkg::C_IN_VALID:  cond_true = in_valid;
            sfs_pkg::C_DIV_DONE:  cond_true = ~div_stat.busy;
            sfs_pkg::C_LOOP_EXIT: cond_true = (VB'(d_reg) > div_q);
            sfs_pkg::C_REM_NZ:    cond_true = (div_r != '0);
            sfs_pkg::C_NOT_ODD:   cond_true = ~odd_reg;
            sfs_pkg::C_REM_NE_D:  cond_true = (rem_reg != VB'(d_reg));
            sfs_pkg::C_REM_LE1:   cond_true = (rem_reg <= VB'(1));
            sfs_pkg::C_OUT_FREE:  cond_true = out_free;
            default:              cond_true = 1'b0;
        endcase

        if (cond_true)
        begin
            pc_next = uw.target;
        end
        else if (uw.hold)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    // datapath
    always_comb
    begin
        rem_next       = rem_reg;
        d_next         = d_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        odd_next       = odd_reg;
        prod_next      = prod_reg;
        root_next      = root_reg;
        free_next      = free_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        mul_x          = b_reg;
        mul_y          = VB'(d_reg);

        case (uw.op)
            sfs_pkg::OP_MUL_AD:
            begin
                mul_x = VB'(a_reg);
            end
            sfs_pkg::OP_MUL_BR:
            begin
                mul_y = rem_reg;
            end
            default:
            begin
            end
        endcase

        case (uw.op)
            sfs_pkg::OP_LOAD:
            begin
                if (in_valid)
                begin
                    rem_next = VB'(value);
                    d_next   = sfs_pkg::FIRST_DIVISOR;
                    a_next   = DB'(1);
                    b_next   = VB'(1);
                    odd_next = 1'b0;
                end
            end
            sfs_pkg::OP_HIT:
            begin
                rem_next = div_q;
                odd_next = ~odd_reg;
            end
            sfs_pkg::OP_MUL_AD, sfs_pkg::OP_MUL_BD, sfs_pkg::OP_MUL_BR:
            begin
                prod_next = mul_x * mul_y;
            end
            sfs_pkg::OP_WR_A:
            begin
                a_next = prod_reg[DB-1:0];
            end
            sfs_pkg::OP_WR_A_REM1:
            begin
                a_next   = prod_reg[DB-1:0];
                rem_next = VB'(1);
            end
            sfs_pkg::OP_WR_B:
            begin
                b_next   = prod_reg[VB-1:0];
                odd_next = 1'b0;
            end
            sfs_pkg::OP_INC_D:
            begin
                // after 2, step over even divisors
                d_next = (d_reg == sfs_pkg::FIRST_DIVISOR) ? DB'(3) : DB'(d_reg + DB'(2));
            end
            sfs_pkg::OP_EMIT:
            begin
                if (out_free)
                begin
                    root_next      = sfs_pkg::ROOT_BITS'(a_reg);
                    free_next      = sfs_pkg::FREE_BITS'(b_reg);
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= sfs_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        d_reg    <= d_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        odd_reg  <= odd_next;
        prod_reg <= prod_next;
        root_reg <= root_next;
        free_reg <= free_next;
    end

    assign out_valid        = out_valid_reg;
    assign square_root_part = root_reg;
    assign square_free_part = free_reg;

    // a finished division always leaves a remainder below the divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == sfs_pkg::S_TEST) |-> (div_r < d_reg))
        else $error("divider remainder not below divisor");

    // never restart the divider while it is still running
    assert property (@(posedge clk) disable iff (!rst_n)
        (uw.op == sfs_pkg::OP_DIV_START) |-> !div_stat.busy)
        else $error("divider started while busy");

    // past the first divisor only odd divisors are tried
    assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg != sfs_pkg::S_IDLE && d_reg != sfs_pkg::FIRST_DIVISOR) |-> d_reg[0])
        else $error("even trial divisor");

    // a new result appears only from the emit step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(pc_reg) == sfs_pkg::S_OUT))
        else $error("result raised outside emit step");

    // both parts are at least one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (root_reg != '0 && free_reg != '0))
        else $error("zero result part");

endmodule
